>>> rtl/twsi_pkg.sv
// Shared types and constants of the threshold window sample integrator.
// No dependencies; the channel interfaces and the top level import it.
package twsi_pkg;

   localparam int SAMPLES_DEFAULT      = 128;
   localparam int MAX_LOOKBACK_DEFAULT = 15;

   localparam int CMD_W      = 2;
   localparam int ADC_W      = 12;
   localparam int IDX_W      = 7;
   localparam int SUM_W      = 24;
   localparam int WSUM_W     = 30;
   localparam int THR_W      = 12;
   localparam int NSA_W      = 6;
   localparam int NSB_W      = 4;
   localparam int WLEN_W     = 6;
   localparam int BASE_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(165);
   localparam logic [NSA_W-1:0]  NSA_RESET  = NSA_W'(10);
   localparam logic [NSB_W-1:0]  NSB_RESET  = NSB_W'(3);
   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(10);
   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(100);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_NSA       = 3'd1,
      CSR_NSB       = 3'd2,
      CSR_WLEN      = 3'd3,
      CSR_BASELINE  = 3'd4
   } csr_idx_type;

endpackage

>>> rtl/twsi_ifs.sv
// Valid/ready channel interfaces of the threshold window sample integrator.
// Depends on twsi_pkg for the payload widths.
interface twsi_req_if import twsi_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [ADC_W-1:0]     adc_value;
   logic                 last_sample;
   logic [IDX_W-1:0]     read_index;

   modport source (output valid, output cmd, output adc_value, output last_sample,
                   output read_index, input ready);
   modport sink   (input valid, input cmd, input adc_value, input last_sample,
                   input read_index, output ready);
endinterface

interface twsi_rsp_if import twsi_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [SUM_W-1:0]     sum_value;
   logic [WSUM_W-1:0]    window_sum;

   modport source (output valid, output sum_value, output window_sum, input ready);
   modport sink   (input valid, input sum_value, input window_sum, output ready);
endinterface

>>> rtl/threshold_window_sample_integrator.sv
// Top level of the threshold window sample integrator.
// Depends on twsi_pkg and on the channel interfaces in twsi_ifs.sv.
//
//   port       dir   handshake        word
//   req_ch     in    valid/ready      cmd, adc_value, last_sample, read_index
//   rsp_ch     out   valid/ready      sum_value, window_sum
//   csr_*      in    csr_wr_en only   csr_index, csr_wdata
//
// A sample outside a window and below threshold only writes the lookback ring; a
// sample inside a window, or one that opens a window, walks the event sum memory,
// folding in the lookback samples (at most min(NSB, MAX_LOOKBACK)) when it opens
// one. A read walks and sums its entries (window_length+1 at most). Adds and reads
// share the one walk over the event sum memory. A clear zeroes all SAMPLES entries.
// Reset starts a clearing pass over all entries; req_ch.ready stays low
// until it ends. A read result waits in the output register while new words
// are taken; a second read holds at its end until the output register frees.
module threshold_window_sample_integrator import twsi_pkg::*; #(
   parameter int SAMPLES      = SAMPLES_DEFAULT,
   parameter int MAX_LOOKBACK = MAX_LOOKBACK_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   twsi_req_if.sink               req_ch,
   twsi_rsp_if.source             rsp_ch
);

   localparam int AW = $clog2(SAMPLES);
   localparam int PW = $clog2(SAMPLES + 1);
   localparam int EW = $clog2(SAMPLES + 62);
   localparam int RW = (MAX_LOOKBACK > 1) ? $clog2(MAX_LOOKBACK) : 1;

   localparam logic [EW-1:0] SAMPLES_E = EW'(SAMPLES);
   localparam logic [6:0]    ML7       = 7'(MAX_LOOKBACK);
   localparam logic [RW-1:0] RING_LAST = RW'(MAX_LOOKBACK - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SAMPLES - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ADD  = 5'b00010,
      ST_RD   = 5'b00100,
      ST_ROUT = 5'b01000,
      ST_CLR  = 5'b10000
   } state_type;

   function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] r);
      ring_inc = (r == RING_LAST) ? '0 : r + 1'b1;
   endfunction

   // configuration
   logic [THR_W-1:0]  thr_ff;
   logic [NSA_W-1:0]  nsa_ff;
   logic [NSB_W-1:0]  nsb_ff;
   logic [WLEN_W-1:0] wlen_ff;
   logic [BASE_W-1:0] base_ff;

   // control state
   state_type         state_ff, state_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [RW-1:0]     wp_ff, wp_in;
   logic              win_ff, win_in;
   logic [EW-1:0]     wend_ff, wend_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // walk and result payload
   logic [ADC_W-1:0]  v_ff, v_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [RW-1:0]     lbw_ff, lbw_in;
   logic [AW-1:0]     s1_q_ff, s1_q_in;
   logic [AW-1:0]     nq_ff, nq_in;
   logic [RW-1:0]     nr_ff, nr_in;
   logic [WSUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [WSUM_W-1:0] rsp_wsum_ff, rsp_wsum_in;

   // memories
   logic [SUM_W-1:0]  ev_mem [SAMPLES];
   logic [SUM_W-1:0]  ev_rd_ff;
   logic              ev_we;
   logic [AW-1:0]     ev_waddr, ev_raddr;
   logic [SUM_W-1:0]  ev_wdata;
   logic [ADC_W-1:0]  lb_mem [MAX_LOOKBACK];
   logic [ADC_W-1:0]  lb_rd_ff;
   logic              lb_we;
   logic [RW-1:0]     lb_waddr, lb_raddr;
   logic [ADC_W-1:0]  lb_wdata;

   // accept-time decode
   logic              accept;
   logic [EW-1:0]     p_e, nsb_e, lo_a, lo_b, start_e, nsa_e;
   logic [EW-1:0]     idx_e, wl_e, rlo_e;
   logic              p_ok, in_win, is_open, idx_ok;
   logic [6:0]        nsb7, back7, wp7, ring7;
   logic [RW-1:0]     ring_start;

   // walk datapath
   logic              s1_final, add_hit;
   logic [ADC_W-1:0]  add_val;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign accept            = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sum_value  = rsp_sum_ff;
   assign rsp_ch.window_sum = rsp_wsum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RESET;
         nsa_ff  <= NSA_RESET;
         nsb_ff  <= NSB_RESET;
         wlen_ff <= WLEN_RESET;
         base_ff <= BASE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_NSA:       nsa_ff  <= csr_wdata[NSA_W-1:0];
            CSR_NSB:       nsb_ff  <= csr_wdata[NSB_W-1:0];
            CSR_WLEN:      wlen_ff <= csr_wdata[WLEN_W-1:0];
            CSR_BASELINE:  base_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // window start: NSB back (capped at MAX_LOOKBACK), clipped at position 0 and at the old window end
   always_comb begin
      p_e        = EW'(pos_ff);
      p_ok       = p_e < SAMPLES_E;
      in_win     = win_ff && (p_e <= wend_ff);
      is_open    = !in_win && (req_ch.adc_value >= thr_ff);
      nsb7       = (7'(nsb_ff) > ML7) ? ML7 : 7'(nsb_ff);
      nsb_e      = EW'(nsb7);
      lo_a       = (p_e >= nsb_e) ? p_e - nsb_e : '0;
      lo_b       = (win_ff && (lo_a <= wend_ff)) ? wend_ff + 1'b1 : lo_a;
      start_e    = in_win ? p_e : lo_b;
      back7      = 7'(p_e - start_e);
      wp7        = 7'(wp_ff);
      ring7      = (wp7 >= back7) ? wp7 - back7 : wp7 + ML7 - back7;
      ring_start = RW'(ring7);
      nsa_e      = (nsa_ff == '0) ? EW'(1) : EW'(nsa_ff);
      idx_e      = EW'(req_ch.read_index);
      idx_ok     = idx_e < SAMPLES_E;
      wl_e       = EW'(wlen_ff);
      rlo_e      = (idx_e >= wl_e) ? idx_e - wl_e : '0;
   end

   always_comb begin
      s1_final = (s1_q_ff == end_ff);
      add_val  = s1_final ? v_ff : lb_rd_ff;
      add_hit  = add_val > base_ff;
      sum_wide = {1'b0, ev_rd_ff} + (SUM_W+1)'(add_val - base_ff);
      sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      wp_in        = wp_ff;
      win_in       = win_ff;
      wend_in      = wend_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      v_in         = v_ff;
      end_in       = end_ff;
      lbw_in       = lbw_ff;
      s1_q_in      = s1_q_ff;
      nq_in        = nq_ff;
      nr_in        = nr_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_wsum_in  = rsp_wsum_ff;
      ev_we        = 1'b0;
      ev_waddr     = s1_q_ff;
      ev_wdata     = sum_sat;
      ev_raddr     = nq_ff;
      lb_we        = 1'b0;
      lb_waddr     = lbw_ff;
      lb_wdata     = v_ff;
      lb_raddr     = nr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // issue the first read in the accept cycle
            ev_raddr = (req_ch.cmd == CMD_READ) ? AW'(rlo_e) : AW'(start_e);
            lb_raddr = ring_start;
            if (accept) begin
               unique case (req_ch.cmd)
                  CMD_ADD: begin
                     if (p_ok) begin
                        pos_in = PW'(p_e + 1'b1);
                        wp_in  = ring_inc(wp_ff);
                        if (is_open) begin
                           win_in  = 1'b1;
                           wend_in = p_e + nsa_e - 1'b1;
                        end
                        if (in_win || is_open) begin
                           state_in = ST_ADD;
                           v_in     = req_ch.adc_value;
                           end_in   = AW'(p_e);
                           lbw_in   = wp_ff;
                           s1_q_in  = AW'(start_e);
                           nq_in    = AW'(start_e) + 1'b1;
                           nr_in    = ring_inc(ring_start);
                        end else begin
                           lb_we    = 1'b1;
                           lb_waddr = wp_ff;
                           lb_wdata = req_ch.adc_value;
                        end
                     end
                     if (req_ch.last_sample) begin
                        pos_in = '0;
                        wp_in  = '0;
                        win_in = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     acc_in = '0;
                     if (idx_ok) begin
                        state_in = ST_RD;
                        end_in   = AW'(idx_e);
                        s1_q_in  = AW'(rlo_e);
                        nq_in    = AW'(rlo_e) + 1'b1;
                     end else begin
                        sum_in   = '0;
                        state_in = ST_ROUT;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            ev_we = add_hit;
            if (s1_final) begin
               // lookback write waits until the oldest ring entry has been read
               lb_we    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               s1_q_in = nq_ff;
               nq_in   = nq_ff + 1'b1;
               nr_in   = ring_inc(nr_ff);
            end
         end
         ST_RD: begin
            // at most 64 entries of 24 bits: the sum cannot reach the 30-bit limit
            acc_in = acc_ff + WSUM_W'(ev_rd_ff);
            if (s1_final) begin
               sum_in   = ev_rd_ff;
               state_in = ST_ROUT;
            end else begin
               s1_q_in = nq_ff;
               nq_in   = nq_ff + 1'b1;
            end
         end
         ST_ROUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_ff;
               rsp_wsum_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_CLR: begin
            ev_we    = 1'b1;
            ev_waddr = clr_ff;
            ev_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         pos_ff       <= '0;
         wp_ff        <= '0;
         win_ff       <= 1'b0;
         wend_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         wp_ff        <= wp_in;
         win_ff       <= win_in;
         wend_ff      <= wend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      end_ff      <= end_in;
      lbw_ff      <= lbw_in;
      s1_q_ff     <= s1_q_in;
      nq_ff       <= nq_in;
      nr_ff       <= nr_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_wsum_ff <= rsp_wsum_in;
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= ev_wdata;
      end
      ev_rd_ff <= ev_mem[ev_raddr];
   end

   always_ff @(posedge clock) begin
      if (lb_we) begin
         lb_mem[lb_waddr] <= lb_wdata;
      end
      lb_rd_ff <= lb_mem[lb_raddr];
   end

`ifndef ASSERT_OFF
   a_rsp_from_rout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff == ST_ROUT))
      else $error("result word raised outside the result state");

   a_ev_write_state: assert property (@(posedge clock) disable iff (reset)
      ev_we |-> (state_ff == ST_ADD || state_ff == ST_CLR))
      else $error("event sum write outside add walk or clear");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD || state_ff == ST_RD) |-> (s1_q_ff <= end_ff))
      else $error("memory walk ran past its last entry");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(SAMPLES))
      else $error("sample position beyond record length");
`endif

endmodule
